FILE: rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clk_i edge, off while rst_ni is low
`define ACWTM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition that must never be seen at a clock edge
`define ACWTM_ASSERT_NEVER(label, cond, msg) \
  `ACWTM_ASSERT(label, !(cond), msg)

`endif

FILE: rtl/acwtm_pkg.sv
// shared constants, types and register codes of the trimmed mean unit
package acwtm_pkg;

  localparam int unsigned CHANNELS   = 32;
  localparam int unsigned WINDOW_LEN = 5;

  localparam int unsigned SAMPLE_W  = 12;
  localparam int unsigned FRAME_W   = 16;
  localparam int unsigned CHAN_W    = 5;
  localparam int unsigned ERR_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CHAN_AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // front queue, power of two deep
  localparam int unsigned MQ_DEPTH = 2;
  localparam int unsigned MQ_AW    = 1;
  localparam int unsigned MQ_CW    = 2;

  // result queue, power of two deep
  localparam int unsigned RQ_DEPTH = 8;
  localparam int unsigned RQ_AW    = 3;
  localparam int unsigned RQ_CW    = 4;
  localparam int unsigned CRED_W   = RQ_CW + 1;

  // five 12-bit samples sum into 15 bits
  localparam int unsigned SUM_W       = 15;
  localparam int unsigned RECIP_W     = 16;
  localparam int unsigned RECIP_SHIFT = 16;
  localparam int unsigned PROD_W      = SUM_W + RECIP_W;
  // ceil(2^16 / 3), exact for dividends below 2^15
  localparam logic [RECIP_W-1:0] RECIP3 = 16'd21846;

  localparam logic [CHAN_W-1:0] CHIP_OFFSET = 5'd16;
  localparam logic [ERR_W-1:0]  ERR_MAX     = 16'hFFFF;

  localparam logic [SAMPLE_W-1:0] LOW_LIMIT_RST  = 12'd0;
  localparam logic [SAMPLE_W-1:0] HIGH_LIMIT_RST = 12'd4095;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_LIMIT  = 2'd0,
    REG_HIGH_LIMIT = 2'd1
  } cfg_reg_e;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef sample_t [WINDOW_LEN-1:0] window_t;

  // one channel's stored state, oldest sample at index 0
  typedef struct packed {
    logic [ERR_W-1:0] err;
    window_t          win;
  } entry_t;

  // classified frame handed from the front to the back
  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    sample_t           sample;
    logic              in_range;
    logic              chan_ok;
  } item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    sample_t           sample;
    logic              in_range;
    logic [ERR_W-1:0]  err;
    sample_t           mean;
  } result_t;

endpackage

FILE: rtl/acwtm_ram.sv
// generic single write port ram with registered read, read-first
module acwtm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/acwtm_front.sv
// front part: limit registers, frame classification and the hand-off queue
module acwtm_front
  import acwtm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  sample_t              cfg_wdata_i,
  input  logic                 push_i,
  output logic                 full_o,
  input  logic [FRAME_W-1:0]   frame_word_i,
  input  logic                 chip_index_i,
  output logic                 item_valid_o,
  input  logic                 item_pop_i,
  output item_t                item_o
);

  sample_t           low_q, high_q;
  item_t             slot_q [MQ_DEPTH];
  logic [MQ_AW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [MQ_CW-1:0]  cnt_q, cnt_d;
  logic              push_acc, pop_acc;
  item_t             cls;
  logic [CHAN_W-1:0] chan;
  sample_t           sample;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= LOW_LIMIT_RST;
      high_q <= HIGH_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_LOW_LIMIT:  low_q  <= cfg_wdata_i;
        REG_HIGH_LIMIT: high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // absolute channel and range check
  always_comb begin
    chan   = CHAN_W'(frame_word_i[FRAME_W-1:SAMPLE_W])
           + (chip_index_i ? CHIP_OFFSET : '0);
    sample = frame_word_i[SAMPLE_W-1:0];
    cls.chan     = chan;
    cls.sample   = sample;
    cls.in_range = (sample > low_q) && (sample < high_q);
    cls.chan_ok  = (32'(chan) < CHANNELS);
  end

  assign full_o       = (cnt_q == MQ_CW'(MQ_DEPTH));
  assign item_valid_o = (cnt_q != '0);
  assign push_acc     = push_i && !full_o;
  assign pop_acc      = item_pop_i && item_valid_o;
  assign item_o       = slot_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_acc && !pop_acc) begin
      cnt_d = cnt_q + MQ_CW'(1);
    end else if (pop_acc && !push_acc) begin
      cnt_d = cnt_q - MQ_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_acc) begin
        wr_ptr_q <= wr_ptr_q + MQ_AW'(1);
      end
      if (pop_acc) begin
        rd_ptr_q <= rd_ptr_q + MQ_AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_acc) begin
      slot_q[wr_ptr_q] <= cls;
    end
  end

endmodule

FILE: rtl/acwtm_back.sv
// back part: window memory read-modify-write and trimmed mean pipeline
module acwtm_back
  import acwtm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  input  item_t            item_i,
  output logic             item_pop_o,
  input  logic [RQ_CW-1:0] res_count_i,
  output logic             res_push_o,
  output result_t          res_o
);

  logic [$bits(entry_t)-1:0] ram_rdata;
  logic [CHAN_AW-1:0]        rd_addr, e_addr;
  logic                      vbit_q [CHANNELS];
  logic [CRED_W-1:0]         credit_used;

  // read stage result
  logic          e_v_q, e_rdv_q;
  item_t         e_item_q;
  entry_t        old_entry, new_entry;
  logic          fwd, wr_en;

  // last write, for a back-to-back update of the same channel
  logic               wb_v_q;
  logic [CHAN_AW-1:0] wb_addr_q;
  entry_t             wb_q;

  // reduction stage
  logic              m1_v_q;
  logic [CHAN_W-1:0] m1_chan_q;
  sample_t           m1_sample_q;
  logic              m1_in_range_q;
  logic [ERR_W-1:0]  m1_err_q;
  window_t           m1_win_q;
  logic [SUM_W-1:0]  sum;
  sample_t           hi, lo;

  // divide stage
  logic              m2_v_q;
  logic [CHAN_W-1:0] m2_chan_q;
  sample_t           m2_sample_q;
  logic              m2_in_range_q;
  logic [ERR_W-1:0]  m2_err_q;
  logic [SUM_W-1:0]  m2_sum_q;
  sample_t           m2_hi_q, m2_lo_q;
  logic [SUM_W-1:0]  trim;
  logic [PROD_W-1:0] prod;

  // take an item only if the result queue can hold everything in flight
  assign credit_used = CRED_W'(res_count_i) + CRED_W'(e_v_q) + CRED_W'(m1_v_q)
                     + CRED_W'(m2_v_q);
  assign item_pop_o  = item_valid_i && (credit_used < CRED_W'(RQ_DEPTH));
  assign rd_addr     = CHAN_AW'(item_i.chan);
  assign e_addr      = CHAN_AW'(e_item_q.chan);
  assign wr_en       = e_v_q && e_item_q.chan_ok;

  acwtm_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CHANNELS)
  ) u_win_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (e_addr),
    .wdata_i (new_entry),
    .re_i    (item_pop_o),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    fwd = wb_v_q && (wb_addr_q == e_addr);
    if (fwd) begin
      old_entry = wb_q;
    end else if (e_rdv_q) begin
      old_entry = entry_t'(ram_rdata);
    end else begin
      old_entry = '0;
    end
    for (int k = 0; k < WINDOW_LEN - 1; k++) begin
      new_entry.win[k] = old_entry.win[k+1];
    end
    new_entry.win[WINDOW_LEN-1] = e_item_q.sample;
    if (!e_item_q.in_range && (old_entry.err != ERR_MAX)) begin
      new_entry.err = old_entry.err + ERR_W'(1);
    end else begin
      new_entry.err = old_entry.err;
    end
  end

  always_comb begin
    sum = '0;
    hi  = m1_win_q[0];
    lo  = m1_win_q[0];
    for (int k = 0; k < WINDOW_LEN; k++) begin
      sum = sum + SUM_W'(m1_win_q[k]);
      if (m1_win_q[k] > hi) begin
        hi = m1_win_q[k];
      end
      if (m1_win_q[k] < lo) begin
        lo = m1_win_q[k];
      end
    end
  end

  // divide by three through the reciprocal
  assign trim = m2_sum_q - SUM_W'(m2_hi_q) - SUM_W'(m2_lo_q);
  assign prod = PROD_W'(trim) * PROD_W'(RECIP3);

  assign res_push_o     = m2_v_q;
  assign res_o.chan     = m2_chan_q;
  assign res_o.sample   = m2_sample_q;
  assign res_o.in_range = m2_in_range_q;
  assign res_o.err      = m2_err_q;
  assign res_o.mean     = prod[RECIP_SHIFT +: SAMPLE_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_q  <= 1'b0;
      m1_v_q <= 1'b0;
      m2_v_q <= 1'b0;
      wb_v_q <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        vbit_q[c] <= 1'b0;
      end
    end else begin
      e_v_q  <= item_pop_o;
      m1_v_q <= e_v_q;
      m2_v_q <= m1_v_q;
      wb_v_q <= wr_en;
      if (wr_en) begin
        vbit_q[e_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      e_item_q <= item_i;
      e_rdv_q  <= item_i.chan_ok && vbit_q[rd_addr];
    end
    if (wr_en) begin
      wb_addr_q <= e_addr;
      wb_q      <= new_entry;
    end
    m1_chan_q     <= e_item_q.chan;
    m1_sample_q   <= e_item_q.sample;
    m1_in_range_q <= e_item_q.in_range;
    m1_err_q      <= e_item_q.chan_ok ? new_entry.err : '0;
    m1_win_q      <= e_item_q.chan_ok ? new_entry.win : '0;
    m2_chan_q     <= m1_chan_q;
    m2_sample_q   <= m1_sample_q;
    m2_in_range_q <= m1_in_range_q;
    m2_err_q      <= m1_err_q;
    m2_sum_q      <= sum;
    m2_hi_q       <= hi;
    m2_lo_q       <= lo;
  end

endmodule

FILE: rtl/acwtm_res_q.sv
// result queue in front of the output ports
module acwtm_res_q
  import acwtm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  result_t          res_i,
  input  logic             pop_i,
  output logic             empty_o,
  output result_t          res_o,
  output logic [RQ_CW-1:0] count_o
);

  result_t          slot_q [RQ_DEPTH];
  logic [RQ_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [RQ_CW-1:0] cnt_q, cnt_d;
  logic             pop_acc;

  assign empty_o = (cnt_q == '0);
  assign pop_acc = pop_i && !empty_o;
  assign res_o   = slot_q[rd_ptr_q];
  assign count_o = cnt_q;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_acc) begin
      cnt_d = cnt_q + RQ_CW'(1);
    end else if (pop_acc && !push_i) begin
      cnt_d = cnt_q - RQ_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + RQ_AW'(1);
      end
      if (pop_acc) begin
        rd_ptr_q <= rd_ptr_q + RQ_AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

FILE: rtl/adc_channel_window_trimmed_mean_unit.sv
// top level of the per-channel five-sample trimmed mean unit
// Each converter frame (bits 15..12 channel, 11..0 sample, plus 16 to the
// channel when chip_index_i is 1) is filed into a per-channel five-sample
// window and a saturating 16-bit error counter; a sample not strictly between
// low_limit and high_limit counts as an error. Every accepted frame yields one
// result transaction with the channel, the sample, the range flag, the error
// count after the update and the mean of the middle three window samples.
// The unit sustains one transaction per clock on both sides while pop keeps
// up: the window memory is read when an item leaves the front queue and
// written in the next cycle, and an entry just written is forwarded straight
// to an update of the same channel in the next cycle, so repeated frames for
// one channel do not stall. full rises when the two-entry front queue is
// full; the eight-entry result queue absorbs pop stalls before the front
// fills up. Windows and counters read as zero after reset through per-channel
// valid bits, so there is no clearing pass. Limits are written through
// cfg_we_i (index 0 low_limit, index 1 high_limit, other indexes ignored);
// the user must write them only while idle, which the unit does not enforce.
`include "assert_macros.svh"

module adc_channel_window_trimmed_mean_unit
  import acwtm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration writes
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [SAMPLE_W-1:0]  cfg_wdata_i,
  // frame input queue side
  input  logic                 push,
  output logic                 full,
  input  logic [FRAME_W-1:0]   frame_word_i,
  input  logic                 chip_index_i,
  // result queue side
  output logic                 empty,
  input  logic                 pop,
  output logic [CHAN_W-1:0]    channel_out_o,
  output logic [SAMPLE_W-1:0]  sample_out_o,
  output logic                 in_range_o,
  output logic [ERR_W-1:0]     error_total_o,
  output logic [SAMPLE_W-1:0]  filtered_mean_o
);

  // classified frame between front and back
  item_t            item;
  logic             item_valid;
  logic             item_pop;

  // back to result queue
  result_t          res_in, res_out;
  logic             res_push;
  logic [RQ_CW-1:0] res_count;

  acwtm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push_i       (push),
    .full_o       (full),
    .frame_word_i (frame_word_i),
    .chip_index_i (chip_index_i),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop),
    .item_o       (item)
  );

  // window update and trimmed mean, credit-limited by result queue room
  acwtm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .res_count_i  (res_count),
    .res_push_o   (res_push),
    .res_o        (res_in)
  );

  acwtm_res_q u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .res_i   (res_in),
    .pop_i   (pop),
    .empty_o (empty),
    .res_o   (res_out),
    .count_o (res_count)
  );

  assign channel_out_o   = res_out.chan;
  assign sample_out_o    = res_out.sample;
  assign in_range_o      = res_out.in_range;
  assign error_total_o   = res_out.err;
  assign filtered_mean_o = res_out.mean;

  // credit scheme must keep the result queue from overflowing
  `ACWTM_ASSERT_NEVER(a_res_overrun, res_push && (res_count == RQ_CW'(RQ_DEPTH)), "result queue overrun")
  // a finished result shows up on the ports on the next cycle
  `ACWTM_ASSERT(a_res_visible, res_push |=> !empty, "pushed result not visible")
  // a pop with no push leaves one fewer result waiting
  `ACWTM_ASSERT(a_pop_count, (pop && !empty && !res_push) |=> (res_count == ($past(res_count) - RQ_CW'(1))), "result count did not drop")
  // the back never takes from an empty front queue
  `ACWTM_ASSERT_NEVER(a_pop_idle_front, item_pop && !item_valid, "back popped empty front queue")

endmodule

FILE: dv/adc_channel_window_trimmed_mean_unit_test.sv
// self-checking testbench for the per-channel five-sample trimmed mean unit
`timescale 1ns / 100ps

module adc_channel_window_trimmed_mean_unit_test
  import acwtm_pkg::*;
;

  localparam int RESULT_LATENCY  = 4;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int RANDOM_ITEMS    = 160;
  localparam int CROSSED_ITEMS   = 40;
  // indexes past the register list, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_3 = 2'd3;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i    = '0;
  logic [SAMPLE_W-1:0]  cfg_wdata_i  = '0;
  logic                 push         = 1'b0;
  logic                 full;
  logic [FRAME_W-1:0]   frame_word_i = '0;
  logic                 chip_index_i = 1'b0;
  logic                 empty;
  logic                 pop          = 1'b0;
  logic [CHAN_W-1:0]    channel_out_o;
  logic [SAMPLE_W-1:0]  sample_out_o;
  logic                 in_range_o;
  logic [ERR_W-1:0]     error_total_o;
  logic [SAMPLE_W-1:0]  filtered_mean_o;

  adc_channel_window_trimmed_mean_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .push           (push),
    .full           (full),
    .frame_word_i   (frame_word_i),
    .chip_index_i   (chip_index_i),
    .empty          (empty),
    .pop            (pop),
    .channel_out_o  (channel_out_o),
    .sample_out_o   (sample_out_o),
    .in_range_o     (in_range_o),
    .error_total_o  (error_total_o),
    .filtered_mean_o(filtered_mean_o)
  );

  always #4 clk_i = ~clk_i;

  // predictor state
  sample_t          window_samples [CHANNELS][WINDOW_LEN];
  logic [ERR_W-1:0] error_counts   [CHANNELS];
  sample_t          low_limit_q    = LOW_LIMIT_RST;
  sample_t          high_limit_q   = HIGH_LIMIT_RST;

  result_t pending_results [$];
  result_t oldest_expected;
  int      fail_count    = 0;
  int      send_idle_pct = 0;
  int      pop_idle_pct  = 0;
  int      hold_off_req  = 0;
  int      hold_off_ack  = 0;
  int      hold_off_left = 0;

  // files one frame into the predicted state and returns its result
  function automatic result_t file_sample(logic [FRAME_W-1:0] fw, logic chip);
    result_t     r;
    int unsigned chan;
    int unsigned sum;
    sample_t     s;
    sample_t     hi;
    sample_t     lo;
    chan       = int'(fw[FRAME_W-1:SAMPLE_W]) + (chip ? int'(CHIP_OFFSET) : 0);
    s          = fw[SAMPLE_W-1:0];
    r.chan     = chan[CHAN_W-1:0];
    r.sample   = s;
    r.in_range = (s > low_limit_q) && (s < high_limit_q);
    r.err      = '0;
    r.mean     = '0;
    if (chan < CHANNELS) begin
      for (int k = 0; k < WINDOW_LEN - 1; k++) begin
        window_samples[chan][k] = window_samples[chan][k+1];
      end
      window_samples[chan][WINDOW_LEN-1] = s;
      if (!r.in_range && error_counts[chan] != ERR_MAX) begin
        error_counts[chan] = error_counts[chan] + 1'b1;
      end
      r.err = error_counts[chan];
      sum   = 0;
      hi    = window_samples[chan][0];
      lo    = window_samples[chan][0];
      for (int k = 0; k < WINDOW_LEN; k++) begin
        if (window_samples[chan][k] > hi) hi = window_samples[chan][k];
        if (window_samples[chan][k] < lo) lo = window_samples[chan][k];
        sum += window_samples[chan][k];
      end
      // middle three of five, rounded toward zero
      r.mean = sample_t'((sum - hi - lo) / 3);
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // one frame transaction, called at a rising edge, returns at the accepting edge
  task automatic push_frame(logic [FRAME_W-1:0] fw, logic chip);
    logic taken;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push         <= 1'b1;
    frame_word_i <= fw;
    chip_index_i <= chip;
    do begin
      @(negedge clk_i);
      taken = !full;
      @(posedge clk_i);
    end while (!taken);
    pending_results.push_back(file_sample(fw, chip));
  endtask

  task automatic wait_results_drained();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (RESULT_LATENCY) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [CFG_IDX_W-1:0] idx, sample_t data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_LOW_LIMIT) low_limit_q = data;
    else if (idx == REG_HIGH_LIMIT) high_limit_q = data;
    @(posedge clk_i);
  endtask

  task automatic set_limits(sample_t lo, sample_t hi);
    wait_results_drained();
    write_limit(REG_LOW_LIMIT, lo);
    write_limit(REG_HIGH_LIMIT, hi);
  endtask

  // field extremes, limit boundaries, equal limits, unmapped writes
  task automatic test_limit_edges();
    send_idle_pct = 0;
    pop_idle_pct  = 0;
    // samples equal to the reset limits count as errors
    push_frame(16'h0000, 1'b0);
    push_frame(16'hFFFF, 1'b1);
    push_frame(16'h0001, 1'b0);
    push_frame(16'hFFFE, 1'b1);
    // back-to-back frames on one channel fill its window
    push_frame(16'h500A, 1'b0);
    push_frame(16'h5FA0, 1'b0);
    push_frame(16'h5014, 1'b0);
    push_frame(16'h501E, 1'b0);
    push_frame(16'h5000, 1'b0);
    push_frame(16'h5FFF, 1'b0);
    set_limits(12'd100, 12'd200);
    push_frame(16'h3063, 1'b1);
    push_frame(16'h3064, 1'b1);
    push_frame(16'h3065, 1'b1);
    push_frame(16'h30C7, 1'b1);
    push_frame(16'h30C8, 1'b1);
    push_frame(16'h30C9, 1'b1);
    // equal limits leave nothing in range
    set_limits(12'd500, 12'd500);
    push_frame(16'hA1F4, 1'b0);
    push_frame(16'hA1F3, 1'b0);
    push_frame(16'hA1F5, 1'b0);
    wait_results_drained();
    write_limit(REG_UNMAPPED_2, 12'hFFF);
    write_limit(REG_UNMAPPED_3, 12'h000);
    push_frame(16'hA1F4, 1'b1);
    push_frame(16'hA7FF, 1'b1);
    set_limits(LOW_LIMIT_RST, HIGH_LIMIT_RST);
  endtask

  task automatic test_random_traffic(int items, int send_pct, int pop_pct);
    logic [CHAN_W-1:0] hot [2];
    logic [CHAN_W-1:0] chan;
    sample_t           smp;
    send_idle_pct = send_pct;
    pop_idle_pct  = pop_pct;
    hot[0] = CHAN_W'($urandom_range(0, 31));
    hot[1] = CHAN_W'($urandom_range(0, 31));
    for (int n = 0; n < items; n++) begin
      // two hot channels keep hitting the same-channel forwarding path
      if ($urandom_range(0, 9) < 4) chan = hot[$urandom_range(0, 1)];
      else chan = CHAN_W'($urandom_range(0, 31));
      case ($urandom_range(0, 9))
        0:       smp = '0;
        1:       smp = '1;
        2:       smp = low_limit_q + sample_t'($urandom_range(0, 2)) - 1'b1;
        3:       smp = high_limit_q + sample_t'($urandom_range(0, 2)) - 1'b1;
        default: smp = sample_t'($urandom);
      endcase
      push_frame({chan[3:0], smp}, chan[4]);
    end
  endtask

  // long pop hold-off while frames keep coming, so full rises
  task automatic test_backpressure();
    send_idle_pct = 0;
    pop_idle_pct  = 0;
    hold_off_req++;
    test_random_traffic(60, 0, 0);
    wait_results_drained();
  endtask

  // crossed limits make every sample an error on a busy channel
  task automatic test_crossed_limits();
    set_limits(12'd4095, 12'd0);
    send_idle_pct = 0;
    pop_idle_pct  = 0;
    for (int n = 0; n < CROSSED_ITEMS; n++) begin
      push_frame({4'h7, sample_t'($urandom)}, 1'b1);
    end
    push_frame({4'h7, sample_t'($urandom)}, 1'b0);
    wait_results_drained();
  endtask

  // receiver side: random pop, or a counted hold-off on request
  always @(posedge clk_i) begin
    if (hold_off_ack != hold_off_req) begin
      hold_off_ack  = hold_off_req;
      hold_off_left = HOLD_OFF_CYCLES;
    end
    if (hold_off_left > 0) begin
      hold_off_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= pop_idle_pct);
    end
  end

  // outputs are stable at the falling edge, the transaction lands at the next rise
  always @(negedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction on channel %0d", channel_out_o);
        fail_count++;
      end else begin
        oldest_expected = pending_results.pop_front();
        check_field("channel_out", oldest_expected.chan, channel_out_o);
        check_field("sample_out", oldest_expected.sample, sample_out_o);
        check_field("in_range", oldest_expected.in_range, in_range_o);
        check_field("error_total", oldest_expected.err, error_total_o);
        check_field("filtered_mean", oldest_expected.mean, filtered_mean_o);
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("adc_channel_window_trimmed_mean_unit_test failed");
    $finish;
  end

  initial begin
    for (int c = 0; c < CHANNELS; c++) begin
      error_counts[c] = '0;
      for (int k = 0; k < WINDOW_LEN; k++) window_samples[c][k] = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_limit_edges();
    test_random_traffic(RANDOM_ITEMS, 7, 61);
    set_limits(sample_t'($urandom_range(0, 2047)), sample_t'($urandom_range(2048, 4095)));
    test_random_traffic(RANDOM_ITEMS, 61, 7);
    set_limits(sample_t'($urandom), sample_t'($urandom));
    test_random_traffic(RANDOM_ITEMS, 0, 0);
    set_limits(12'd0, 12'd4095);
    test_backpressure();
    test_crossed_limits();

    wait_results_drained();
    repeat (RESULT_LATENCY * 4) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("adc_channel_window_trimmed_mean_unit_test passed");
    end else begin
      $display("adc_channel_window_trimmed_mean_unit_test failed");
    end
    $finish;
  end

endmodule
